@@ design/tcfp_pkg.sv @@
// Shared types and constants for the tether command frame parser.
`timescale 1ns / 1ps

package tcfp_pkg;

    localparam int NUM_FIELDS = 5;

    localparam logic [7:0] CH_CTRL  = 8'h43;  // 'C'
    localparam logic [7:0] CH_GAIN  = 8'h47;  // 'G'
    localparam logic [7:0] CH_END   = 8'h3B;  // ';'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    localparam logic [15:0] STALE_LIMIT_RESET = 16'd1500;

    typedef enum logic [1:0] {
        KIND_CTRL  = 2'd0,
        KIND_GAIN  = 2'd1,
        KIND_STALE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FT_UNKNOWN = 2'd0,
        FT_CTRL    = 2'd1,
        FT_GAIN    = 2'd2
    } frame_type_t;

    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_COMMA  = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

endpackage

@@ design/tether_command_frame_parser.sv @@
// Tether command frame parser: byte-serial C/G frame checker with stale timeout.
`timescale 1ns / 1ps

// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_ready, mode, byte_value      | in
// result   | out_valid, out_ready, kind, control_mode, | out
//          | value_a..value_e, stale                   |
// config   | cfg_valid, cfg_ready, cfg_data            | in
//
// One input transaction per cycle while in_ready is high. All parsing for a
// byte or poll is done in one pass of combinational logic; the result goes
// into a single output register on acceptance. in_ready drops only while that
// register holds a result that the sink has not taken. cfg_ready is always
// high. rst_n clears all control state; stale_limit resets to 1500.
//
// Frames: 'C' d,n,n,n,n;  or  'G' n,n,n,n,n;  with leading white space
// skipped before each field. A frame that reaches BUFFER_BYTES bytes is
// dropped and the next byte starts a new frame. Values saturate to 32 bits.
// Every byte reloads the stale counter; each poll counts it down and once
// below zero each poll yields a stale result with all values zero.

module tether_command_frame_parser #(
    parameter int BUFFER_BYTES = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [7:0]           byte_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [3:0]           control_mode,
    output logic signed [31:0]   value_a,
    output logic signed [31:0]   value_b,
    output logic signed [31:0]   value_c,
    output logic signed [31:0]   value_d,
    output logic signed [31:0]   value_e,
    output logic                 stale,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    import tcfp_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    // Control state
    logic [15:0]        stale_limit_reg;
    logic signed [16:0] stale_cnt_reg, stale_cnt_next;
    logic               collecting_reg, collecting_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    frame_type_t        ftype_reg, ftype_next;
    logic [2:0]         fidx_reg, fidx_next;
    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [31:0]        acc_reg, acc_next;
    logic               failed_reg, failed_next;

    // Field store (payload)
    logic [31:0]        store_reg [NUM_FIELDS];
    logic [31:0]        store_next [NUM_FIELDS];

    // Output register
    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg;
    logic [3:0]         cmode_reg;
    logic [31:0]        val_reg [NUM_FIELDS];

    logic               in_fire;
    logic               res_valid;
    kind_t              res_kind;
    logic [3:0]         res_cmode;
    logic [31:0]        res_val [NUM_FIELDS];

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [7:0]       c;
        logic [3:0]       dig;
        logic             is_dig;
        logic             is_sp;
        logic [35:0]      acc_w;
        logic [35:0]      prod;
        logic [31:0]      fin;
        logic [CNT_W-1:0] cnt_inc;
        logic             ok;

        c       = byte_value;
        dig     = c[3:0];
        is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sp   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        acc_w   = {4'b0, acc_reg};
        prod    = (acc_w << 3) + (acc_w << 1) + {32'b0, dig};
        // close of a value: negate or clamp the saturated magnitude
        fin     = neg_reg ? (32'd0 - acc_reg) : ((acc_reg > POS_MAX) ? POS_MAX : acc_reg);
        cnt_inc = count_reg + CNT_W'(1);
        ok      = 1'b0;

        stale_cnt_next  = stale_cnt_reg;
        collecting_next = collecting_reg;
        count_next      = count_reg;
        ftype_next      = ftype_reg;
        fidx_next       = fidx_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        failed_next     = failed_reg;
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            store_next[k] = store_reg[k];
            res_val[k]    = '0;
        end
        res_valid = 1'b0;
        res_kind  = KIND_CTRL;
        res_cmode = '0;

        if (mode)
        begin
            // empty poll
            if (!stale_cnt_reg[16])
            begin
                stale_cnt_next = stale_cnt_reg - 17'sd1;
            end
            if (stale_cnt_next[16])
            begin
                res_valid = 1'b1;
                res_kind  = KIND_STALE;
            end
        end
        else
        begin
            stale_cnt_next = $signed({1'b0, stale_limit_reg});
            if (collecting_reg || c == CH_CTRL || c == CH_GAIN)
            begin
                if (!failed_reg)
                begin
                    unique case (phase_reg)
                        PH_FIRST:
                        begin
                            if (c == CH_CTRL)
                            begin
                                ftype_next = FT_CTRL;
                                fidx_next  = '0;
                                phase_next = PH_SKIP;
                            end
                            else if (c == CH_GAIN)
                            begin
                                ftype_next = FT_GAIN;
                                fidx_next  = '0;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_SKIP:
                        begin
                            if (is_sp)
                            begin
                                // skip white space
                            end
                            else if (ftype_reg == FT_CTRL && fidx_reg == 3'd0)
                            begin
                                if (is_dig)
                                begin
                                    store_next[0] = {28'b0, dig};
                                    fidx_next     = 3'd1;
                                    phase_next    = PH_COMMA;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            else if (c == CH_PLUS || c == CH_MINUS)
                            begin
                                neg_next   = (c == CH_MINUS);
                                acc_next   = '0;
                                phase_next = PH_SIGNED;
                            end
                            else if (is_dig)
                            begin
                                neg_next   = 1'b0;
                                acc_next   = {28'b0, dig};
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_SIGNED:
                        begin
                            if (is_dig)
                            begin
                                acc_next   = {28'b0, dig};
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_dig)
                            begin
                                acc_next = (prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
                            end
                            else
                            begin
                                if (fidx_reg < 3'(NUM_FIELDS))
                                begin
                                    store_next[fidx_reg] = fin;
                                end
                                fidx_next = fidx_reg + 3'd1;
                                neg_next  = 1'b0;
                                acc_next  = '0;
                                if (fidx_next >= 3'(NUM_FIELDS))
                                begin
                                    phase_next = PH_DONE;
                                end
                                else if (c == CH_COMMA)
                                begin
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                        end
                        PH_COMMA:
                        begin
                            if (c == CH_COMMA)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_DONE:
                        begin
                            // trailing text up to ';' is not checked
                        end
                        default:
                        begin
                            failed_next = 1'b1;
                        end
                    endcase
                end

                ok = !failed_next && (phase_next == PH_DONE);

                if (cnt_inc >= CNT_W'(BUFFER_BYTES))
                begin
                    // overflow: drop frame, keep collecting
                    collecting_next = 1'b1;
                    count_next      = '0;
                    ftype_next      = FT_UNKNOWN;
                    fidx_next       = '0;
                    phase_next      = PH_FIRST;
                    neg_next        = 1'b0;
                    acc_next        = '0;
                    failed_next     = 1'b0;
                end
                else if (c == CH_END)
                begin
                    if (ok && ftype_next == FT_CTRL)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_CTRL;
                        res_cmode = store_next[0][3:0];
                        for (int k = 1; k < NUM_FIELDS; k++)
                        begin
                            res_val[k-1] = store_next[k];
                        end
                    end
                    else if (ok && ftype_next == FT_GAIN)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_GAIN;
                        for (int k = 0; k < NUM_FIELDS; k++)
                        begin
                            res_val[k] = store_next[k];
                        end
                    end
                    collecting_next = 1'b0;
                    count_next      = '0;
                    ftype_next      = FT_UNKNOWN;
                    fidx_next       = '0;
                    phase_next      = PH_FIRST;
                    neg_next        = 1'b0;
                    acc_next        = '0;
                    failed_next     = 1'b0;
                end
                else
                begin
                    collecting_next = 1'b1;
                    count_next      = cnt_inc;
                end
            end
        end
    end

    assign out_valid_next = (in_fire && res_valid) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= STALE_LIMIT_RESET;
            stale_cnt_reg   <= '0;
            collecting_reg  <= 1'b0;
            count_reg       <= '0;
            ftype_reg       <= FT_UNKNOWN;
            fidx_reg        <= '0;
            phase_reg       <= PH_FIRST;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            failed_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                stale_limit_reg <= cfg_data;
            end
            if (in_fire)
            begin
                stale_cnt_reg  <= stale_cnt_next;
                collecting_reg <= collecting_next;
                count_reg      <= count_next;
                ftype_reg      <= ftype_next;
                fidx_reg       <= fidx_next;
                phase_reg      <= phase_next;
                neg_reg        <= neg_next;
                acc_reg        <= acc_next;
                failed_reg     <= failed_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: field store and result register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                store_reg[k] <= store_next[k];
            end
        end
        if (in_fire && res_valid)
        begin
            kind_reg  <= res_kind;
            cmode_reg <= res_cmode;
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                val_reg[k] <= res_val[k];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign control_mode = cmode_reg;
    assign value_a      = $signed(val_reg[0]);
    assign value_b      = $signed(val_reg[1]);
    assign value_c      = $signed(val_reg[2]);
    assign value_d      = $signed(val_reg[3]);
    assign value_e      = $signed(val_reg[4]);
    assign stale        = (kind_reg == KIND_STALE);

endmodule

@@ tb/sv/tcfp_tb_pkg.sv @@
// Scoreboard class: mirrors the frame parser and checks its result transactions.
`timescale 1ns / 1ps

package tcfp_tb_pkg;

    import tcfp_pkg::*;

    localparam int BUF_BYTES   = 40;

    typedef struct {
        kind_t       kind;
        logic [3:0]  cmode;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
        logic [31:0] vd;
        logic [31:0] ve;
        logic        stale;
    } frame_result_t;

    class frame_checker;
        bit [15:0]     stale_limit;
        bit            collecting;
        int unsigned   byte_count;
        frame_type_t   ftype;
        int unsigned   fidx;
        phase_t        phase;
        bit            neg;
        bit [31:0]     acc;
        bit            bad;
        bit [31:0]     fields [NUM_FIELDS];
        int            stale_cnt;   // -1 .. 65535
        frame_result_t due_outputs [$];
        int            errors;
        int            n_ctrl;
        int            n_gain;
        int            n_stale;

        function new();
            stale_limit = STALE_LIMIT_RESET;
            collecting  = 1'b0;
            stale_cnt   = 0;
            errors      = 0;
            n_ctrl      = 0;
            n_gain      = 0;
            n_stale     = 0;
            foreach (fields[k])
                fields[k] = '0;
            new_frame();
        endfunction

        function void new_frame();
            byte_count = 0;
            ftype      = FT_UNKNOWN;
            fidx       = 0;
            phase      = PH_FIRST;
            neg        = 1'b0;
            acc        = '0;
            bad        = 1'b0;
        endfunction

        function bit is_space(bit [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_digit(bit [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // Close the current value: apply sign, clamp positive side.
        function void store_value();
            bit [31:0] v;
            if (neg)
                v = 32'd0 - acc;
            else
                v = (acc > POS_MAX) ? POS_MAX : acc;
            if (fidx < NUM_FIELDS)
                fields[fidx] = v;
            fidx++;
            neg = 1'b0;
            acc = '0;
        endfunction

        function void parse_char(bit [7:0] c);
            bit [63:0] t;
            if (bad || phase == PH_DONE)
                return;
            case (phase)
                PH_FIRST:
                begin
                    if (c == CH_CTRL)
                        ftype = FT_CTRL;
                    else if (c == CH_GAIN)
                        ftype = FT_GAIN;
                    else
                    begin
                        bad = 1'b1;
                        return;
                    end
                    fidx  = 0;
                    phase = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (!is_space(c))
                    begin
                        if (ftype == FT_CTRL && fidx == 0)
                        begin
                            if (is_digit(c))
                            begin
                                fields[0] = c - CH_ZERO;
                                fidx      = 1;
                                phase     = PH_COMMA;
                            end
                            else
                                bad = 1'b1;
                        end
                        else if (c == CH_PLUS || c == CH_MINUS)
                        begin
                            neg   = (c == CH_MINUS);
                            acc   = '0;
                            phase = PH_SIGNED;
                        end
                        else if (is_digit(c))
                        begin
                            neg   = 1'b0;
                            acc   = c - CH_ZERO;
                            phase = PH_DIGITS;
                        end
                        else
                            bad = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    if (is_digit(c))
                    begin
                        acc   = c - CH_ZERO;
                        phase = PH_DIGITS;
                    end
                    else
                        bad = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        t   = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
                        acc = (t > {32'd0, MAG_LIMIT}) ? MAG_LIMIT : t[31:0];
                    end
                    else
                    begin
                        store_value();
                        if (fidx >= NUM_FIELDS)
                            phase = PH_DONE;
                        else if (c == CH_COMMA)
                            phase = PH_SKIP;
                        else
                            bad = 1'b1;
                    end
                end
                PH_COMMA:
                begin
                    if (c == CH_COMMA)
                        phase = PH_SKIP;
                    else
                        bad = 1'b1;
                end
                default:
                    bad = 1'b1;
            endcase
        endfunction

        // One accepted input transaction: byte or empty poll.
        function void absorb_input(bit poll, bit [7:0] c);
            frame_result_t r;
            if (poll)
            begin
                if (stale_cnt >= 0)
                    stale_cnt--;
                if (stale_cnt < 0)
                begin
                    r = '{KIND_STALE, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
                    due_outputs.push_back(r);
                end
                return;
            end
            stale_cnt = int'(stale_limit);
            if (c == CH_CTRL || c == CH_GAIN)
                collecting = 1'b1;
            if (!collecting)
                return;
            parse_char(c);
            byte_count++;
            if (byte_count >= BUF_BYTES)
            begin
                new_frame();
                return;
            end
            if (c != CH_END)
                return;
            collecting = 1'b0;
            if (!bad && phase == PH_DONE)
            begin
                if (ftype == FT_CTRL)
                begin
                    r = '{KIND_CTRL, fields[0][3:0], fields[1], fields[2], fields[3],
                          fields[4], 32'd0, 1'b0};
                    due_outputs.push_back(r);
                end
                else if (ftype == FT_GAIN)
                begin
                    r = '{KIND_GAIN, 4'd0, fields[0], fields[1], fields[2], fields[3],
                          fields[4], 1'b0};
                    due_outputs.push_back(r);
                end
            end
            new_frame();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, $signed(want), $signed(got));
            end
        endfunction

        // One accepted result transaction, compared with the oldest one due.
        function void match_output(frame_result_t got);
            frame_result_t want;
            if (due_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: result with none due, expected nothing, actual kind %0d",
                         $time, got.kind);
                return;
            end
            want = due_outputs.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("control_mode", want.cmode, got.cmode);
            check_field("value_a", want.va, got.va);
            check_field("value_b", want.vb, got.vb);
            check_field("value_c", want.vc, got.vc);
            check_field("value_d", want.vd, got.vd);
            check_field("value_e", want.ve, got.ve);
            check_field("stale", want.stale, got.stale);
            case (want.kind)
                KIND_CTRL:  n_ctrl++;
                KIND_GAIN:  n_gain++;
                default:    n_stale++;
            endcase
        endfunction
    endclass

endpackage

@@ tb/sv/tb_tether_command_frame_parser.sv @@
// Testbench top for the tether command frame parser: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb_tether_command_frame_parser;

    import tcfp_pkg::*;
    import tcfp_tb_pkg::*;

    localparam int RAND_ITEMS     = 1250;  // random bytes and polls, noise not counted
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on any channel
    localparam int SETTLE_CYCLES  = 6;
    localparam int RX_HOLD_CYCLES = 300;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               mode       = 1'b0;
    logic [7:0]         byte_value = 8'd0;
    logic               out_ready  = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic [15:0]        cfg_data   = 16'd0;

    logic               in_ready;
    logic               out_valid;
    logic [1:0]         kind;
    logic [3:0]         control_mode;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
    logic               stale;
    logic               cfg_ready;

    frame_checker sb = new();

    int item_count   = 0;
    int cfg_count    = 0;
    int quiet_cycles = 0;
    int rx_hold_req  = 0;   // picked up and counted down by the receiver
    bit burst        = 1'b0; // no random idling on either side while set

    tether_command_frame_parser #(
        .BUFFER_BYTES (BUF_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .byte_value   (byte_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .control_mode (control_mode),
        .value_a      (value_a),
        .value_b      (value_b),
        .value_c      (value_c),
        .value_d      (value_d),
        .value_e      (value_e),
        .stale        (stale),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Monitor: everything is sampled at the rising edge, before the NBA updates land.
    // The result is checked before the input is noted, since a result can never come
    // from the transaction accepted at the same edge.
    always @(posedge clk)
    begin : monitor
        frame_result_t seen;
        bit            moved;
        moved = 1'b0;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{kind_t'(kind), control_mode, value_a, value_b, value_c, value_d,
                     value_e, stale};
            sb.match_output(seen);
            moved = 1'b1;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            sb.stale_limit = cfg_data;
            moved = 1'b1;
        end
        if (rst_n && in_valid && in_ready)
        begin
            sb.absorb_input(mode, byte_value);
            moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // Watchdog: a hung handshake or a missing result shows up as a quiet stretch.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        $display("%0t: no transaction for %0d cycles, %0d results still due",
                 $time, WATCHDOG_LIMIT, sb.due_outputs.size());
        $display("tether_command_frame_parser regression: fail");
        $finish;
    end

    // Result side: random stalls, mostly short, plus long hold-offs on request.
    initial
    begin
        int stall;
        int hold;
        int r;
        stall = 0;
        hold  = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (burst || r < 65)
                    stall = 0;
                else if (r < 88)
                    stall = $urandom_range(1, 3);
                else if (r < 97)
                    stall = $urandom_range(4, 10);
                else
                    stall = $urandom_range(20, 50);
            end
        end
    end

    // Sender idle length after a transaction.
    function automatic int next_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one input transaction and hold it until accepted. Valid is left high
    // when the next transaction follows straight away.
    task automatic send_item(input bit poll, input bit [7:0] c, input bit counted);
        int gap;
        in_valid   <= 1'b1;
        mode       <= poll;
        byte_value <= c;
        do
            @(posedge clk);
        while (!in_ready);
        if (counted)
            item_count++;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i], 1'b1);
    endtask

    // Poll payload is don't-care, so it is random to exercise every bit.
    task automatic send_polls(input int n);
        repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stray bytes that cannot open a frame.
    task automatic send_noise(input int n);
        bit [7:0] b;
        repeat (n)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_CTRL || b == CH_GAIN);
            send_item(1'b0, b, 1'b0);
        end
    endtask

    // Stop offering, let every due result drain, then allow the pipe to settle.
    // One edge first so the monitor has noted the last accepted transaction.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stale_limit(input bit [15:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_count++;
    endtask

    function automatic string zeros(input int n);
        string s;
        s = "";
        repeat (n) s = {s, "0"};
        return s;
    endfunction

    // Leading white space: usually none, sometimes one or two of the six kinds.
    function automatic string make_ws();
        string        s;
        byte unsigned pick [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        int           n;
        s = "";
        n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
        repeat (n) s = $sformatf("%s%c", s, pick[$urandom_range(0, 5)]);
        return s;
    endfunction

    // Signed decimal, mostly short; some near the 32-bit edge, some far past it.
    function automatic string make_number();
        string           sign;
        string           digits;
        int              r;
        longint unsigned mag;
        r    = $urandom_range(0, 3);
        sign = (r == 0) ? "-" : (r == 1) ? "+" : "";
        r    = $urandom_range(0, 99);
        if (r < 55)
            mag = $urandom_range(0, 999);
        else if (r < 78)
            mag = $urandom_range(0, 999999);
        else if (r < 92)
            mag = 64'd2147483640 + $urandom_range(0, 16);
        else
            mag = {$urandom, $urandom} % 64'd1000000000000;
        digits = $sformatf("%0d", mag);
        if ($urandom_range(0, 19) == 0)
            digits = {"00", digits};
        return {sign, digits};
    endfunction

    // A C or G frame with random content; a broken one gets one random defect.
    function automatic string make_frame(input bit well_formed);
        string s;
        string junk;
        bit    ctrl;
        int    pos;
        junk = ",-+ C;G";
        ctrl = $urandom_range(0, 1);
        s    = ctrl ? "C" : "G";
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            if (k > 0)
                s = {s, ","};
            s = {s, make_ws()};
            if (ctrl && k == 0)
                s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            else
                s = {s, make_number()};
        end
        if ($urandom_range(0, 9) == 0)
            s = {s, " x,+-"};   // tail after the fifth value is not checked
        s = {s, ";"};
        if (!well_formed)
        begin
            pos = $urandom_range(1, s.len() - 2);
            case ($urandom_range(0, 3))
                0:       s.putc(pos, 8'($urandom_range(1, 255)));
                1:       s = s.substr(0, s.len() - 2);   // frame runs into the next one
                2:       s = {s.substr(0, pos - 1), $sformatf("%c", junk[$urandom_range(0, 6)]),
                              s.substr(pos, s.len() - 1)};
                default: s = {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
            endcase
        end
        return s;
    endfunction

    initial
    begin
        bit [15:0] limits [4];
        int        r;
        int        base;
        int        target;
        int        mid;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Stale counter comes out of reset at zero, so the very first poll is stale,
        // and it keeps reporting stale while the counter sits at -1.
        send_polls(2);
        // Plain control and gain frames, white space of every kind before fields.
        send_text("C3,1000,-250,+7,0;");
        send_text("C \t7,1,2,3,4;");
        send_text("G 1, -2,\t3,\0154,\n\013\0145;");
        // Field extremes and saturation on both sides.
        send_text("G2147483647,-2147483648,99999999999,-99999999999,+0;");
        send_text("C9,2147483648,-2147483649,0,-0;");
        // Bytes outside a frame are dropped until 'C' or 'G' shows up.
        send_text("xy;Z");
        send_text("C0,1,2,3,4;");
        // Frame letters inside a frame are just bad characters.
        send_text("G1,2,C,3,4;");
        send_text("CG1,2,3,4,5;");
        // Malformed: two-digit mode, signed mode, bare sign, short frame, space before comma.
        send_text("C12,1,2,3,4;");
        send_text("C-1,1,1,1,1;");
        send_text("G1,-,3,4,5;");
        send_text("G+,1,2,3,4;");
        send_text("G1,2,3,4;");
        send_text("C5 ,1,2,3,4;");
        // Text after the fifth value is accepted unchecked.
        send_text("G1,2,3,4,5 junk,;");
        send_text("C1,2,3,4,5,6;");
        // Buffer limit: 39 bytes pass, 40 bytes drop even on the ';'. The byte after
        // a drop opens the next frame, good or bad.
        send_text({"G1,2,3,4,", zeros(28), "5;"});
        send_text({"G1,2,3,4,", zeros(29), "5;"});
        send_text("x1;");
        send_text({"G1,2,3,4,", zeros(29), "5;"});
        send_text("C1,1,1,1,1;");
        send_text({"G", zeros(45), ",1,2,3,4;"});

        // Stale limit zero: a single poll after a byte already times out.
        write_stale_limit(16'd0);
        send_item(1'b0, "a", 1'b1);
        send_polls(2);
        // Limit two: the third poll is the first stale one.
        write_stale_limit(16'd2);
        send_item(1'b0, "q", 1'b1);
        send_polls(4);
        // Receiver holds off while polls keep coming back to back, so the result
        // register fills and input backs up; then the sender waits for a full drain.
        rx_hold_req = RX_HOLD_CYCLES;
        burst       = 1'b1;
        send_item(1'b0, "z", 1'b1);
        send_polls(30);
        burst = 1'b0;
        wait_idle();
        // Largest limit: polls never reach stale.
        write_stale_limit(16'hFFFF);
        send_text("C4,5,6,7,8;");
        send_polls(5);

        // ---- random part: four settings of stale_limit ----
        limits[0] = 16'($urandom_range(0, 4));
        limits[1] = 16'hFFFF;
        limits[2] = STALE_LIMIT_RESET;
        limits[3] = 16'($urandom_range(0, 30));
        base = item_count;
        for (int p = 0; p < 4; p++)
        begin
            write_stale_limit(limits[p]);
            target = base + RAND_ITEMS * (p + 1) / 4;
            mid    = base + RAND_ITEMS * p / 4 + RAND_ITEMS / 8;
            while (item_count < target)
            begin
                // first half of the third setting runs with no idling at all
                burst = (p == 2) && (item_count < mid);
                r = $urandom_range(0, 99);
                if (r < 62)
                    send_text(make_frame(1'b1));
                else if (r < 77)
                    send_text(make_frame(1'b0));
                else if (r < 93)
                    send_polls(($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                           : $urandom_range(1, 6));
                else
                    send_noise($urandom_range(1, 3));
            end
            burst = 1'b0;
        end

        wait_idle();
        $display("covered %0d byte/poll transactions and %0d stale_limit writes",
                 item_count, cfg_count);
        $display("checked %0d control, %0d gain, %0d stale results; %0d mismatches",
                 sb.n_ctrl, sb.n_gain, sb.n_stale, sb.errors);
        if (sb.errors == 0 && sb.due_outputs.size() == 0)
            $display("tether_command_frame_parser regression: pass");
        else
            $display("tether_command_frame_parser regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/tcfp_pkg.sv
design/tether_command_frame_parser.sv
tb/sv/tcfp_tb_pkg.sv
tb/sv/tb_tether_command_frame_parser.sv
